[design/imr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the image rescaler.
// Depends on nothing; every other file of the block but imr_ram and imr_checker uses it.
package imr_pkg;

  localparam int COORD_W = 12;  // source and destination coordinates
  localparam int DIM_W   = 13;  // clamped source and destination sizes
  localparam int FRAC_W  = 8;   // Q0.8 blend fraction
  localparam int PIX_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_REQ  = 1'b1;

  // Pixel modes
  localparam logic [1:0] MODE_PALETTE = 2'd0;
  localparam logic [1:0] MODE_RGB     = 2'd1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE = 3'd4;

  typedef struct packed {
    logic                 op;
    logic [7:0]           src_x;
    logic [7:0]           src_y;
    logic [PIX_W-1:0]     src_pixel;
    logic [COORD_W-1:0]   dst_x;
    logic [COORD_W-1:0]   dst_y;
  } in_word_t;

  // Effective configuration, sizes already clamped to their legal range
  typedef struct packed {
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [DIM_W-1:0] dw;
    logic [DIM_W-1:0] dh;
    logic [1:0]       mode;
  } cfg_t;

  // Request after coordinate mapping
  typedef struct packed {
    in_word_t            w;
    logic [COORD_W-1:0]  ix;
    logic [COORD_W-1:0]  iy;
    logic [FRAC_W-1:0]   fx;
    logic [FRAC_W-1:0]   fy;
  } pos_word_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } out_word_t;

endpackage

[design/imr_if.sv]
`timescale 1ns / 1ps
// Channel interfaces of the image rescaler: input, result and config write.
// Depends on imr_pkg for field widths.
interface imr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [7:0]                    src_x;
  logic [7:0]                    src_y;
  logic [imr_pkg::PIX_W-1:0]     src_pixel;
  logic [imr_pkg::COORD_W-1:0]   dst_x;
  logic [imr_pkg::COORD_W-1:0]   dst_y;
  modport source (output valid, op, src_x, src_y, src_pixel, dst_x, dst_y, input ready);
  modport sink   (input valid, op, src_x, src_y, src_pixel, dst_x, dst_y, output ready);
endinterface

interface imr_out_if;
  logic                          valid;
  logic                          ready;
  logic [imr_pkg::PIX_W-1:0]     out_pixel;
  logic [imr_pkg::COORD_W-1:0]   out_x;
  logic [imr_pkg::COORD_W-1:0]   out_y;
  modport source (output valid, out_pixel, out_x, out_y, input ready);
  modport sink   (input valid, out_pixel, out_x, out_y, output ready);
endinterface

interface imr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [imr_pkg::CFG_IDX_W-1:0]   index;
  logic [imr_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/imr_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the image store banks.
module imr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/imr_map.sv]
`timescale 1ns / 1ps
// Coordinate mapping pipeline: dst*src/dst as integer part and Q0.8 fraction.
// One multiply stage, two long-division steps per stage, one clamp stage. Uses imr_pkg.
module imr_map (
  input  logic               clk,
  input  logic               rst_n,
  input  imr_pkg::in_word_t  in_word,
  input  logic               in_valid,
  output logic               in_ready,
  input  imr_pkg::cfg_t      cfg,
  output imr_pkg::pos_word_t pos_word,
  output logic               pos_valid,
  input  logic               pos_ready
);

  localparam int PW  = imr_pkg::COORD_W + imr_pkg::DIM_W;  // product width
  localparam int QW  = PW + imr_pkg::FRAC_W;               // quotient width
  localparam int SPS = 2;                                  // steps per stage
  localparam int NST = (QW + SPS - 1) / SPS;
  localparam int DW  = imr_pkg::DIM_W;

  logic [NST+1:0]      v_r;
  logic [NST+2:0]      en;
  imr_pkg::in_word_t   w_r  [NST+1];
  logic [QW-1:0]       qx_r [NST+1];
  logic [QW-1:0]       qy_r [NST+1];
  logic [DW-1:0]       rx_r [NST+1];
  logic [DW-1:0]       ry_r [NST+1];
  imr_pkg::pos_word_t  pos_r;
  logic [PW-1:0]       prod_x;
  logic [PW-1:0]       prod_y;

  // Restoring division, up to SPS quotient bits starting at bit number first
  function automatic logic [DW+QW-1:0] div_steps(input logic [DW-1:0] r_in,
                                                 input logic [QW-1:0] q_in,
                                                 input logic [DW-1:0] d,
                                                 input int first);
    logic [DW-1:0] r;
    logic [QW-1:0] q;
    logic [DW:0]   t;
    r = r_in;
    q = q_in;
    for (int j = 0; j < SPS; j++) begin
      if (first + j < QW) begin
        t = {r, q[QW-1]};
        q = {q[QW-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
          t    = t - {1'b0, d};
          q[0] = 1'b1;
        end
        r = t[DW-1:0];
      end
    end
    return {r, q};
  endfunction

  // Stage enables: a stage moves when empty or when the next one moves
  assign en[NST+2] = pos_ready;
  for (genvar k = 0; k <= NST + 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign in_ready  = en[0];
  assign pos_valid = v_r[NST+1];
  assign pos_word  = pos_r;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k <= NST + 1; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Multiply stage
  assign prod_x = PW'(in_word.dst_x) * PW'(cfg.sw);
  assign prod_y = PW'(in_word.dst_y) * PW'(cfg.sh);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      w_r[0]  <= in_word;
      qx_r[0] <= {prod_x, imr_pkg::FRAC_W'(0)};
      qy_r[0] <= {prod_y, imr_pkg::FRAC_W'(0)};
      rx_r[0] <= '0;
      ry_r[0] <= '0;
    end
  end

  // Division stages
  for (genvar k = 1; k <= NST; k++) begin : g_div
    logic [QW-1:0] qx_nxt;
    logic [QW-1:0] qy_nxt;
    logic [DW-1:0] rx_nxt;
    logic [DW-1:0] ry_nxt;

    always_comb begin
      {rx_nxt, qx_nxt} = div_steps(rx_r[k-1], qx_r[k-1], cfg.dw, (k - 1) * SPS);
      {ry_nxt, qy_nxt} = div_steps(ry_r[k-1], qy_r[k-1], cfg.dh, (k - 1) * SPS);
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        w_r[k]  <= w_r[k-1];
        qx_r[k] <= qx_nxt;
        qy_r[k] <= qy_nxt;
        rx_r[k] <= rx_nxt;
        ry_r[k] <= ry_nxt;
      end
    end
  end

  // Clamp stage: saturate to last column or row with zero fraction
  logic [PW-1:0] ipx;
  logic [PW-1:0] ipy;
  imr_pkg::pos_word_t pos_nxt;

  always_comb begin
    ipx = qx_r[NST][QW-1:imr_pkg::FRAC_W];
    ipy = qy_r[NST][QW-1:imr_pkg::FRAC_W];
    pos_nxt.w = w_r[NST];
    if (ipx >= PW'(cfg.sw)) begin
      pos_nxt.ix = imr_pkg::COORD_W'(cfg.sw - DW'(1));
      pos_nxt.fx = '0;
    end else begin
      pos_nxt.ix = imr_pkg::COORD_W'(ipx);
      pos_nxt.fx = qx_r[NST][imr_pkg::FRAC_W-1:0];
    end
    if (ipy >= PW'(cfg.sh)) begin
      pos_nxt.iy = imr_pkg::COORD_W'(cfg.sh - DW'(1));
      pos_nxt.fy = '0;
    end else begin
      pos_nxt.iy = imr_pkg::COORD_W'(ipy);
      pos_nxt.fy = qy_r[NST][imr_pkg::FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST+1]) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

[design/imr_blend.sv]
`timescale 1ns / 1ps
// Image store in four banks by coordinate parity, and the blend pipeline.
// Stages: address, store read, products, sum and scale, output. Uses imr_pkg, imr_ram.
module imr_blend #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  imr_pkg::pos_word_t pos_word,
  input  logic               pos_valid,
  output logic               pos_ready,
  input  imr_pkg::cfg_t      cfg,
  output imr_pkg::out_word_t out_word,
  output logic               out_valid,
  input  logic               out_ready
);

  localparam int HALF_W = (MAX_SRC_WIDTH + 1) / 2;
  localparam int HALF_H = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int BDEPTH = HALF_W * HALF_H;
  localparam int AW     = BDEPTH > 1 ? $clog2(BDEPTH) : 1;
  localparam int CW     = imr_pkg::COORD_W;
  localparam int DW     = imr_pkg::DIM_W;

  typedef struct packed {
    logic          ix0;
    logic          iy0;
    logic          hr;
    logic          hd;
    logic [7:0]    fx;
    logic [7:0]    fy;
    logic [CW-1:0] dx;
    logic [CW-1:0] dy;
  } meta_t;

  function automatic logic [AW-1:0] bank_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(int'(r[CW-1:1]) * HALF_W + int'(c[CW-1:1]));
  endfunction

  logic en_a, en_rd, en_m, en_u, en_o;
  logic va_r, vrd_r, vm_r, vu_r, vo_r;

  assign en_o      = !vo_r || out_ready;
  assign en_u      = !vu_r || en_o;
  assign en_m      = !vm_r || en_u;
  assign en_rd     = !vrd_r || en_m;
  assign en_a      = !va_r || en_rd;
  assign pos_ready = en_a;

  // Advance valid bits; loads leave after the address stage
  logic isreq_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      vrd_r <= 1'b0;
      vm_r  <= 1'b0;
      vu_r  <= 1'b0;
      vo_r  <= 1'b0;
    end else begin
      if (en_a)  va_r  <= pos_valid;
      if (en_rd) vrd_r <= va_r && isreq_r;
      if (en_m)  vm_r  <= vrd_r;
      if (en_u)  vu_r  <= vm_r;
      if (en_o)  vo_r  <= vu_r;
    end
  end

  // Address stage: neighbor columns and rows per bank, or the load target
  logic [AW-1:0]    addr_nxt [4];
  logic [3:0]       wbank_nxt;
  meta_t            meta_nxt;
  logic [CW-1:0]    xr, yd, col, row, lx, ly;
  logic             ld_ok;

  always_comb begin
    meta_nxt.hr  = pos_word.ix != CW'(cfg.sw - DW'(1));
    meta_nxt.hd  = pos_word.iy != CW'(cfg.sh - DW'(1));
    meta_nxt.ix0 = pos_word.ix[0];
    meta_nxt.iy0 = pos_word.iy[0];
    meta_nxt.fx  = pos_word.fx;
    meta_nxt.fy  = pos_word.fy;
    meta_nxt.dx  = pos_word.w.dst_x;
    meta_nxt.dy  = pos_word.w.dst_y;
    xr = meta_nxt.hr ? pos_word.ix + CW'(1) : pos_word.ix;
    yd = meta_nxt.hd ? pos_word.iy + CW'(1) : pos_word.iy;
    lx = CW'(pos_word.w.src_x);
    ly = CW'(pos_word.w.src_y);
    ld_ok = (DW'(pos_word.w.src_x) < DW'(MAX_SRC_WIDTH)) &&
            (DW'(pos_word.w.src_y) < DW'(MAX_SRC_HEIGHT));
    wbank_nxt = '0;
    col = '0;
    row = '0;
    for (int b = 0; b < 4; b++) begin
      if (pos_word.w.op == imr_pkg::OP_LOAD) begin
        addr_nxt[b]  = bank_addr(ly, lx);
        wbank_nxt[b] = ld_ok && (lx[0] == b[0]) && (ly[0] == b[1]);
      end else begin
        col = (pos_word.ix[0] == b[0]) ? pos_word.ix : xr;
        row = (pos_word.iy[0] == b[1]) ? pos_word.iy : yd;
        addr_nxt[b] = bank_addr(row, col);
      end
    end
  end

  logic [AW-1:0]    addr_r [4];
  logic [3:0]       wbank_r;
  logic [31:0]      wdata_r;
  meta_t            meta_a_r;

  always_ff @(posedge clk) begin
    if (en_a) begin
      addr_r   <= addr_nxt;
      wbank_r  <= wbank_nxt;
      wdata_r  <= pos_word.w.src_pixel;
      meta_a_r <= meta_nxt;
      isreq_r  <= pos_word.w.op == imr_pkg::OP_REQ;
    end
  end

  // Store banks; bank index is {row parity, column parity}
  logic [31:0] rd_data [4];
  for (genvar b = 0; b < 4; b++) begin : g_bank
    imr_ram #(.WIDTH(32), .DEPTH(BDEPTH)) u_ram (
      .clk   (clk),
      .we    (va_r && en_rd && !isreq_r && wbank_r[b]),
      .waddr (addr_r[b]),
      .wdata (wdata_r),
      .re    (va_r && en_rd && isreq_r),
      .raddr (addr_r[b]),
      .rdata (rd_data[b])
    );
  end

  meta_t meta_rd_r;
  always_ff @(posedge clk) begin
    if (en_rd) begin
      meta_rd_r <= meta_a_r;
    end
  end

  // Product stage: S = c1*(1536-3fs) + 2*c2*fy + 2*c3*fx + c4*fs, fs = fx+fy
  logic [31:0] p1, p2, p3, p4;
  logic [8:0]  fs;
  logic [10:0] k1;
  logic [18:0] m1_nxt [4];
  logic [16:0] m2_nxt [4], m3_nxt [4], m4_nxt [4];

  always_comb begin
    p1 = rd_data[{meta_rd_r.iy0, meta_rd_r.ix0}];
    p2 = meta_rd_r.hd ? rd_data[{!meta_rd_r.iy0, meta_rd_r.ix0}] : p1;
    p3 = meta_rd_r.hr ? rd_data[{meta_rd_r.iy0, !meta_rd_r.ix0}] : p1;
    p4 = (meta_rd_r.hd && meta_rd_r.hr) ? rd_data[{!meta_rd_r.iy0, !meta_rd_r.ix0}] : p1;
    fs = 9'(meta_rd_r.fx) + 9'(meta_rd_r.fy);
    k1 = 11'd1536 - 11'(fs) - 11'(fs) - 11'(fs);
    for (int k = 0; k < 4; k++) begin
      m1_nxt[k] = 19'(p1[8*k +: 8]) * 19'(k1);
      m2_nxt[k] = 17'(p2[8*k +: 8]) * 17'({meta_rd_r.fy, 1'b0});
      m3_nxt[k] = 17'(p3[8*k +: 8]) * 17'({meta_rd_r.fx, 1'b0});
      m4_nxt[k] = 17'(p4[8*k +: 8]) * 17'(fs);
    end
  end

  logic [18:0]   m1_r [4];
  logic [16:0]   m2_r [4], m3_r [4], m4_r [4];
  logic [7:0]    lo_m_r, lo_u_r;
  logic [CW-1:0] dx_m_r, dy_m_r, dx_u_r, dy_u_r;

  always_ff @(posedge clk) begin
    if (en_m) begin
      m1_r   <= m1_nxt;
      m2_r   <= m2_nxt;
      m3_r   <= m3_nxt;
      m4_r   <= m4_nxt;
      lo_m_r <= p1[7:0];
      dx_m_r <= meta_rd_r.dx;
      dy_m_r <= meta_rd_r.dy;
    end
  end

  // Sum and scale: floor((S+768)/1536) as floor(floor((S+768)/512)/3)
  logic [19:0] s_sum;
  logic [9:0]  s_hi;
  logic [19:0] s_tri;
  logic [7:0]  ch_nxt [4];

  always_comb begin
    s_sum = '0;
    s_hi  = '0;
    s_tri = '0;
    for (int k = 0; k < 4; k++) begin
      s_sum = 20'(m1_r[k]) + 20'(m2_r[k]) + 20'(m3_r[k]) + 20'(m4_r[k]) + 20'd768;
      s_hi  = s_sum[18:9];
      s_tri = 20'(s_hi) * 20'd683;
      ch_nxt[k] = (s_tri[19:11] > 9'd255) ? 8'd255 : s_tri[18:11];
    end
  end

  logic [7:0] ch_r [4];
  always_ff @(posedge clk) begin
    if (en_u) begin
      ch_r   <= ch_nxt;
      lo_u_r <= lo_m_r;
      dx_u_r <= dx_m_r;
      dy_u_r <= dy_m_r;
    end
  end

  // Output register: pack channels by mode
  imr_pkg::out_word_t out_r;
  always_ff @(posedge clk) begin
    if (en_o) begin
      out_r.x <= dx_u_r;
      out_r.y <= dy_u_r;
      if (cfg.mode == imr_pkg::MODE_PALETTE) begin
        out_r.pixel <= {24'd0, lo_u_r};
      end else if (cfg.mode == imr_pkg::MODE_RGB) begin
        out_r.pixel <= {8'd0, ch_r[2], ch_r[1], ch_r[0]};
      end else begin
        out_r.pixel <= {ch_r[3], ch_r[2], ch_r[1], ch_r[0]};
      end
    end
  end

  assign out_word  = out_r;
  assign out_valid = vo_r;

endmodule

[design/image_rescaler.sv]
`timescale 1ns / 1ps
// Image rescaler top level: config registers, mapping pipeline, blend pipeline.
// Each accepted request gives one result word; loads give no word.
// Throughput: one word per cycle, loads and requests alike, but each stage holds its
// word while downstream stalls. The store is split into four banks by column and row
// parity, so a request's four neighbors are read in the same cycle, one read per bank.
// Reset (synchronous, rst_n low) clears all valid bits and sets the config registers
// to 256 x 256 source, 256 x 256 destination, four-channel mode; the store is not cleared.
module image_rescaler #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  imr_in_if.sink     in_ch,
  imr_out_if.source  out_ch,
  imr_cfg_if.sink    cfg_ch
);

  localparam int DW = imr_pkg::DIM_W;

  logic [8:0]  src_width_r, src_height_r;
  logic [12:0] dst_width_r, dst_height_r;
  logic [1:0]  pixel_mode_r;

  // Config register writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= 9'd256;
      src_height_r <= 9'd256;
      dst_width_r  <= 13'd256;
      dst_height_r <= 13'd256;
      pixel_mode_r <= 2'd2;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        imr_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_ch.data[8:0];
        imr_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_ch.data[8:0];
        imr_pkg::CFG_DST_WIDTH:  dst_width_r  <= cfg_ch.data;
        imr_pkg::CFG_DST_HEIGHT: dst_height_r <= cfg_ch.data;
        imr_pkg::CFG_PIXEL_MODE: pixel_mode_r <= cfg_ch.data[1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes to their legal range
  imr_pkg::cfg_t cfg;
  always_comb begin
    if (src_width_r == 9'd0) begin
      cfg.sw = DW'(1);
    end else if (DW'(src_width_r) > DW'(MAX_SRC_WIDTH)) begin
      cfg.sw = DW'(MAX_SRC_WIDTH);
    end else begin
      cfg.sw = DW'(src_width_r);
    end
    if (src_height_r == 9'd0) begin
      cfg.sh = DW'(1);
    end else if (DW'(src_height_r) > DW'(MAX_SRC_HEIGHT)) begin
      cfg.sh = DW'(MAX_SRC_HEIGHT);
    end else begin
      cfg.sh = DW'(src_height_r);
    end
    cfg.dw   = (dst_width_r == 13'd0) ? DW'(1) : dst_width_r;
    cfg.dh   = (dst_height_r == 13'd0) ? DW'(1) : dst_height_r;
    cfg.mode = pixel_mode_r;
  end

  imr_pkg::in_word_t  in_word;
  imr_pkg::pos_word_t pos_word;
  imr_pkg::out_word_t out_word;
  logic               pos_valid, pos_ready;

  always_comb begin
    in_word.op        = in_ch.op;
    in_word.src_x     = in_ch.src_x;
    in_word.src_y     = in_ch.src_y;
    in_word.src_pixel = in_ch.src_pixel;
    in_word.dst_x     = in_ch.dst_x;
    in_word.dst_y     = in_ch.dst_y;
  end

  imr_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .cfg       (cfg),
    .pos_word  (pos_word),
    .pos_valid (pos_valid),
    .pos_ready (pos_ready)
  );

  imr_blend #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .pos_word  (pos_word),
    .pos_valid (pos_valid),
    .pos_ready (pos_ready),
    .cfg       (cfg),
    .out_word  (out_word),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

  assign out_ch.out_pixel = out_word.pixel;
  assign out_ch.out_x     = out_word.x;
  assign out_ch.out_y     = out_word.y;

endmodule

[design/imr_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the image rescaler result channel, and their bind.
// Depends on image_rescaler and the channel interfaces.
module imr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel,
  input logic [11:0] out_x,
  input logic [11:0] out_y
);

  // Hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel) && $stable(out_x) && $stable(out_y))
    else $error("result word changed while stalled");

  // Drop any word during reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The pipeline is empty right after reset
  a_startup: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result word too soon after reset");

endmodule

bind image_rescaler imr_checker u_imr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_pixel (out_ch.out_pixel),
  .out_x     (out_ch.out_x),
  .out_y     (out_ch.out_y)
);
